[rtl/core/pld_pkg.sv]
// Shared types, constants and divide helper for the pyramid level block.
`default_nettype none

package pld_pkg;

  localparam int CHAN_W                 = 8;
  localparam int CFG_INDEX_W            = 1;
  localparam int CFG_DATA_W             = 13;
  localparam int DEFAULT_MAX_HALF_WIDTH = 1024;
  localparam int RESULT_FIFO_DEPTH      = 4;

  localparam logic [11:0] RESET_SOURCE_WIDTH  = 12'd640;
  localparam logic [12:0] RESET_SOURCE_HEIGHT = 13'd480;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

  // weight totals of the clipped 3x3 binomial kernel
  localparam logic [4:0] WEIGHT_16 = 5'd16;
  localparam logic [4:0] WEIGHT_12 = 5'd12;
  localparam logic [4:0] WEIGHT_9  = 5'd9;
  localparam logic [4:0] WEIGHT_8  = 5'd8;
  localparam logic [4:0] WEIGHT_6  = 5'd6;
  localparam logic [4:0] WEIGHT_4  = 5'd4;

  // reciprocals: x/3 = x*683 >> 11 for x < 2048, x/9 = x*3641 >> 15 for x < 32768
  localparam logic [11:0] RECIP_3 = 12'd683;
  localparam logic [11:0] RECIP_9 = 12'd3641;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // one store word: the same column of all three lines
  typedef rgb_t [2:0] column_t;

  typedef struct packed {
    rgb_t pix;
    logic frame_end;
  } result_t;

  typedef enum logic [2:0] {
    FORM_PREV = 3'b001,  // row above the newest one, up to three taps high
    FORM_LAST = 3'b010,  // newest row of the frame, no row below
    FORM_ONLY = 3'b100   // frame of one half-size row
  } job_form_t;

  // line that lies n rows back from line rot, modulo three
  function automatic logic [1:0] slot_back(input logic [1:0] rot, input logic [1:0] n);
    logic [2:0] s;
    s = {1'b0, rot} + 3'd3 - {1'b0, n};
    if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return s[1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] div_weight(input logic [11:0] s, input logic [4:0] w);
    logic [23:0] prod;
    logic [11:0] q;
    prod = '0;
    unique case (w)
      WEIGHT_16: q = s >> 4;
      WEIGHT_8:  q = s >> 3;
      WEIGHT_4:  q = s >> 2;
      WEIGHT_12: begin
        prod = {12'd0, 2'd0, s[11:2]} * {12'd0, RECIP_3};
        q = prod[22:11];
      end
      WEIGHT_6: begin
        prod = {12'd0, 1'b0, s[11:1]} * {12'd0, RECIP_3};
        q = prod[22:11];
      end
      WEIGHT_9: begin
        prod = {12'd0, s} * {12'd0, RECIP_9};
        q = {3'd0, prod[23:15]};
      end
      default: q = s >> 4;
    endcase
    return q[CHAN_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/pld_if.sv]
// Handshake interfaces for source pixels, smoothed results and register writes.
`default_nettype none

interface pld_pixel_if
  import pld_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface pld_result_if
  import pld_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic              frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

interface pld_cfg_if
  import pld_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/pyramid_level_decimate_blur.sv]
// Half-size pyramid level: decimate by two, then 3x3 binomial smoothing per channel.
//
// Channels: pixels takes one RGB source pixel per item in raster order; results
// gives one smoothed half-size pixel per item, frame_end set on the last pixel of
// the half-size frame; cfg writes source_width (index 0) and source_height
// (index 1) and is always ready.
// Throughput: one source pixel per cycle while no pending job or full queue holds
// it back. Rows at even positions go into a three-line store (one 72-bit word per
// column, one line lane written per kept pixel); in odd rows but the first (unless
// that is also the last) each kept even column starts one smoothing job (two in the
// final odd row of a frame over one half-size row high). Jobs read the store at the
// next column, so a 3x3 window slides along the row; the column at x = 0 comes from
// the second read port. Pipeline: the store read and the stage 1 sums are registered,
// then stage 2 divides and writes into the output queue. The final odd row's second
// job of a column is held pending; an even-row pixel waits while it is pending.
// Reset: counters and line rotation go to zero and registers to 640 x 480; the
// store is not cleared, each line is written before it is read.
// Stall: results sit in a four-entry queue; jobs issue only while the queue and
// the pipeline together have room, otherwise pixels that start a job wait.
`default_nettype none

module pyramid_level_decimate_blur
  import pld_pkg::*;
#(
  parameter int MAX_HALF_WIDTH = DEFAULT_MAX_HALF_WIDTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  pld_pixel_if.sink     pixels,
  pld_result_if.source  results,
  pld_cfg_if.sink       cfg
);

  localparam int AW  = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
  localparam int CW  = $clog2(RESULT_FIFO_DEPTH + 1);
  localparam int PW  = $clog2(RESULT_FIFO_DEPTH);

  typedef struct packed {
    logic [AW-1:0]   x;
    logic            x_zero;
    logic            x_last;
    logic [2:0]      row_v;
    logic [2:0][1:0] slot;
    logic            frame_end;
  } job_t;

  // registers
  logic [11:0] source_width;
  logic [12:0] source_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= RESET_SOURCE_WIDTH;
      source_height <= RESET_SOURCE_HEIGHT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SOURCE_WIDTH:  source_width  <= cfg.data[11:0];
        REG_SOURCE_HEIGHT: source_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // position counters
  logic [11:0] col;
  logic [12:0] row;
  logic [1:0]  rot;

  logic [12:0] hw_wide;
  logic [11:0] hh;
  logic [10:0] c;
  logic [11:0] k;
  logic        kept, is_last, dual, single, gen, store_wr, in_acc;

  always_comb begin
    hw_wide = ({2'b00, source_width[11:1]} > 13'(MAX_HALF_WIDTH)) ?
              13'(MAX_HALF_WIDTH) : {2'b00, source_width[11:1]};
    hh      = source_height[12:1];
    c       = col[11:1];
    k       = row[12:1];
    kept    = !col[0] && ({2'b00, c} < hw_wide) && (k < hh);
    is_last = ({1'b0, k} + 13'd1) == {1'b0, hh};
    single  = is_last && (hh == 12'd1);
    dual    = is_last && (hh != 12'd1);
    gen     = kept && row[0] && (is_last || (k != 12'd0));
  end

  function automatic job_t make_job(input logic [12:0] xi, input job_form_t form,
                                    input logic [12:0] hwv, input logic [1:0] r,
                                    input logic deep);
    job_t j;
    j.x      = xi[AW-1:0];
    j.x_zero = (xi == 13'd0);
    j.x_last = (xi + 13'd1) == hwv;
    unique case (form)
      FORM_PREV: begin
        j.slot      = {r, slot_back(r, 2'd1), slot_back(r, 2'd2)};
        j.row_v     = {1'b1, 1'b1, deep};
        j.frame_end = 1'b0;
      end
      FORM_LAST: begin
        j.slot      = {r, r, slot_back(r, 2'd1)};
        j.row_v     = 3'b011;
        j.frame_end = j.x_last;
      end
      default: begin
        j.slot      = {r, r, r};
        j.row_v     = 3'b010;
        j.frame_end = j.x_last;
      end
    endcase
    return j;
  endfunction

  job_t        job_first, job_second;
  logic [12:0] p0, p1;
  logic        deep;

  always_comb begin
    p0   = {1'b0, c, 1'b0};
    p1   = {1'b0, c, 1'b1};
    deep = (k[11:1] != 11'd0);
    if (dual) begin
      job_first  = (p0 < hw_wide) ? make_job(p0, FORM_PREV, hw_wide, rot, deep) :
                                    make_job(p0 - hw_wide, FORM_LAST, hw_wide, rot, deep);
      job_second = (p1 < hw_wide) ? make_job(p1, FORM_PREV, hw_wide, rot, deep) :
                                    make_job(p1 - hw_wide, FORM_LAST, hw_wide, rot, deep);
    end else if (single) begin
      job_first  = make_job({2'b00, c}, FORM_ONLY, hw_wide, rot, deep);
      job_second = job_first;
    end else begin
      job_first  = make_job({2'b00, c}, FORM_PREV, hw_wide, rot, deep);
      job_second = job_first;
    end
  end

  // job issue and output credit
  logic          pend_v;
  job_t          pend_job;
  logic          s1_v, s2_v;
  logic [CW-1:0] fifo_count;
  logic          credit_ok, issue_in, issue_pend, issue;
  job_t          issue_job;

  assign credit_ok = ({1'b0, fifo_count} + (CW+1)'(s1_v) + (CW+1)'(s2_v))
                     < (CW+1)'(RESULT_FIFO_DEPTH);
  // a pending job reads the store: hold back store writes and new jobs meanwhile
  assign pixels.ready = !(gen && (pend_v || !credit_ok)) &&
                        !(pend_v && kept && !row[0]);
  assign in_acc     = pixels.valid && pixels.ready;
  assign issue_in   = in_acc && gen;
  assign issue_pend = pend_v && credit_ok;
  assign issue      = issue_in || issue_pend;
  assign issue_job  = pend_v ? pend_job : job_first;
  assign store_wr   = in_acc && kept && !row[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (issue_in && dual) begin
      pend_v <= 1'b1;
    end else if (issue_pend) begin
      pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_in) begin
      pend_job <= job_second;
    end
  end

  // counters advance on every accepted pixel
  logic [12:0] col_inc;
  logic [13:0] row_inc;

  assign col_inc = {1'b0, col} + 13'd1;
  assign row_inc = {1'b0, row} + 14'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      rot <= '0;
    end else if (in_acc) begin
      if (col_inc >= {1'b0, source_width}) begin
        col <= '0;
        if (row_inc >= {1'b0, source_height}) begin
          row <= '0;
          rot <= '0;
        end else begin
          row <= row_inc[12:0];
          if (row[0]) begin
            rot <= (rot == 2'd2) ? 2'd0 : rot + 2'd1;
          end
        end
      end else begin
        col <= col_inc[11:0];
      end
    end
  end

  // line store: one write lane, two read ports, registered reads
  column_t       line_store [MAX_HALF_WIDTH];
  column_t       rd_a, rd_b;
  logic [AW-1:0] addr_a;
  rgb_t          in_pix;

  assign addr_a = issue_job.x_last ? issue_job.x : issue_job.x + AW'(1);
  assign in_pix = '{red: pixels.red_in, green: pixels.green_in, blue: pixels.blue_in};

  always_ff @(posedge clk) begin
    if (store_wr) begin
      line_store[c[AW-1:0]][rot] <= in_pix;
    end
    if (issue) begin
      rd_a <= line_store[addr_a];
      rd_b <= line_store[issue_job.x];
    end
  end

  // stage 1: slide the window and form weighted sums
  job_t    s1_job;
  column_t win_m, win_r;
  column_t col_l, col_m, col_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_job <= issue_job;
    end
    if (s1_v) begin
      win_m <= col_m;
      win_r <= col_r;
    end
  end

  assign col_r = rd_a;
  assign col_m = s1_job.x_zero ? rd_b : win_r;
  assign col_l = win_m;

  logic [2:0][11:0] sum1;
  logic [4:0]       wsum1;

  always_comb begin
    logic [2:0][9:0] rs;
    logic [2:0]      row_w;
    logic [2:0][7:0] tl, tm, tr;
    logic [1:0]      n_rows;
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        tl[i] = col_l[s1_job.slot[i]][8*ch +: 8];
        tm[i] = col_m[s1_job.slot[i]][8*ch +: 8];
        tr[i] = col_r[s1_job.slot[i]][8*ch +: 8];
        rs[i] = (s1_job.x_zero ? 10'd0 : {2'b00, tl[i]}) + {1'b0, tm[i], 1'b0} +
                (s1_job.x_last ? 10'd0 : {2'b00, tr[i]});
        if (!s1_job.row_v[i]) begin
          rs[i] = '0;
        end
      end
      sum1[ch] = {2'b00, rs[0]} + {1'b0, rs[1], 1'b0} + {2'b00, rs[2]};
    end
    row_w  = 3'd2 + {2'b00, !s1_job.x_zero} + {2'b00, !s1_job.x_last};
    n_rows = {1'b0, s1_job.row_v[0]} + {1'b0, s1_job.row_v[2]};
    // middle row always counts twice
    wsum1  = {2'b00, row_w} * ({3'b000, n_rows} + 5'd2);
  end

  // stage 2: divide by the weight total and queue the result
  logic [2:0][11:0] s2_sum;
  logic [4:0]       s2_wsum;
  logic             s2_fe;
  result_t          res2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v) begin
      s2_sum  <= sum1;
      s2_wsum <= wsum1;
      s2_fe   <= s1_job.frame_end;
    end
  end

  assign res2.pix.blue  = div_weight(s2_sum[0], s2_wsum);
  assign res2.pix.green = div_weight(s2_sum[1], s2_wsum);
  assign res2.pix.red   = div_weight(s2_sum[2], s2_wsum);
  assign res2.frame_end = s2_fe;

  // result queue
  result_t       fifo [RESULT_FIFO_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic          pop;

  assign pop = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr       <= '0;
      rptr       <= '0;
      fifo_count <= '0;
    end else begin
      if (s2_v) begin
        wptr <= wptr + PW'(1);
      end
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      fifo_count <= fifo_count + CW'(s2_v) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v) begin
      fifo[wptr] <= res2;
    end
  end

  assign results.valid     = (fifo_count != '0);
  assign results.red_out   = fifo[rptr].pix.red;
  assign results.green_out = fifo[rptr].pix.green;
  assign results.blue_out  = fifo[rptr].pix.blue;
  assign results.frame_end = fifo[rptr].frame_end;

  // checks
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, fifo_count} + (CW+1)'(s1_v) + (CW+1)'(s2_v)) <= (CW+1)'(RESULT_FIFO_DEPTH))
    else $error("result queue and pipeline exceed queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s2_v && !pop |-> fifo_count < CW'(RESULT_FIFO_DEPTH))
    else $error("result pushed into full queue");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(store_wr && issue))
    else $error("line store written while a job reads it");

  a_pending_one_shot: assert property (@(posedge clk) disable iff (rst)
    pend_v && credit_ok |=> !pend_v || $past(issue_in))
    else $error("pending job not issued when room was free");

endmodule

`default_nettype wire

[bench/half_frame_checker.sv]
// Checker for the pyramid level block: predicts smoothed half-size pixels and compares them.
module half_frame_checker
  import pld_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  pld_pixel_if   pixels,
  pld_result_if  results,
  pld_cfg_if     cfg,
  output int     errors,
  output int     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_LIMIT = DEFAULT_MAX_HALF_WIDTH;

  rgb_t        lines [3*HALF_LIMIT];
  logic [11:0] width_reg;
  logic [12:0] height_reg;
  int          col_pos;
  int          row_pos;
  int          rot;
  result_t     smoothed_q[$];

  assign outstanding = smoothed_q.size();

  function automatic int tap(input int d);
    return (d == 0) ? 2 : 1;
  endfunction

  function automatic rgb_t blur_at(input int k, input int r, input int c,
                                   input int hh, input int hw);
    int   sr, sg, sb, wsum, y, x, w, slot;
    rgb_t px;
    rgb_t res;
    sr = 0; sg = 0; sb = 0; wsum = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      y = r + dy;
      if (y < 0 || y >= hh || y > k || k - y > 2) continue;
      slot = (rot + 3 - (k - y)) % 3;
      for (int dx = -1; dx <= 1; dx++) begin
        x = c + dx;
        if (x < 0 || x >= hw) continue;
        w = tap(dy) * tap(dx);
        px = lines[slot*HALF_LIMIT + x];
        sr += px.red * w;
        sg += px.green * w;
        sb += px.blue * w;
        wsum += w;
      end
    end
    if (wsum == 0) wsum = 1;
    res.red   = 8'(sr / wsum);
    res.green = 8'(sg / wsum);
    res.blue  = 8'(sb / wsum);
    return res;
  endfunction

  task automatic push_expected(input rgb_t p, input logic last);
    result_t e;
    e.pix = p;
    e.frame_end = last;
    smoothed_q.insert(smoothed_q.size(), e);
  endtask

  task automatic take_source_pixel(input rgb_t p);
    int hw, hh, c, k, r, x;
    hw = int'(width_reg) >> 1;
    hh = int'(height_reg) >> 1;
    if (hw > HALF_LIMIT) hw = HALF_LIMIT;
    c = col_pos >> 1;
    k = row_pos >> 1;
    if ((col_pos % 2) == 0 && c < hw && k < hh) begin
      if ((row_pos % 2) == 0) begin
        lines[rot*HALF_LIMIT + c] = p;
      end else if (k + 1 == hh) begin
        if (hh == 1) begin
          push_expected(blur_at(k, 0, c, hh, hw), c + 1 == hw);
        end else begin
          for (int q = 2*c; q < 2*c + 2; q++) begin
            r = (q < hw) ? k - 1 : k;
            x = (q < hw) ? q : q - hw;
            push_expected(blur_at(k, r, x, hh, hw), r == k && x + 1 == hw);
          end
        end
      end else if (k >= 1) begin
        push_expected(blur_at(k, k - 1, c, hh, hw), 1'b0);
      end
    end
    col_pos++;
    if (col_pos >= int'(width_reg)) begin
      col_pos = 0;
      if (row_pos % 2) rot = (rot + 1) % 3;
      row_pos++;
      if (row_pos >= int'(height_reg)) begin
        row_pos = 0;
        rot = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    rgb_t    p;
    result_t e;
    if (rst) begin
      width_reg  <= RESET_SOURCE_WIDTH;
      height_reg <= RESET_SOURCE_HEIGHT;
      col_pos = 0;
      row_pos = 0;
      rot = 0;
      smoothed_q.delete();
      errors <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_SOURCE_WIDTH) width_reg <= cfg.data[11:0];
        else if (cfg.index == REG_SOURCE_HEIGHT) height_reg <= cfg.data;
      end
      if (pixels.valid && pixels.ready) begin
        p.red   = pixels.red_in;
        p.green = pixels.green_in;
        p.blue  = pixels.blue_in;
        take_source_pixel(p);
      end
      if (results.valid && results.ready) begin
        if (smoothed_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result %h %h %h end %b", $realtime, results.red_out,
                     results.green_out, results.blue_out, results.frame_end);
          errors <= errors + 1;
        end else begin
          e = smoothed_q.pop_front();
          if (e.pix.red != results.red_out || e.pix.green != results.green_out ||
              e.pix.blue != results.blue_out || e.frame_end != results.frame_end) begin
            if (errors < 10)
              $display("%0t: mismatch exp %h %h %h end %b got %h %h %h end %b", $realtime,
                       e.pix.red, e.pix.green, e.pix.blue, e.frame_end, results.red_out,
                       results.green_out, results.blue_out, results.frame_end);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

[bench/tb_top.sv]
// Top of the pyramid level testbench: stimulus, receiver stalls, watchdog and verdict.
module tb_top;
  import pld_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   outstanding;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  bit   long_hold = 1'b0;
  int   quiet_cycles = 0;
  int   fed = 0;

  pld_pixel_if  pixels();
  pld_result_if results();
  pld_cfg_if    cfg();

  pyramid_level_decimate_blur DUT (
    .clk(clk), .rst(rst), .pixels(pixels), .results(results), .cfg(cfg)
  );

  half_frame_checker u_checker (
    .clk(clk), .rst(rst), .pixels(pixels), .results(results), .cfg(cfg),
    .errors(errors), .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    pixels.valid = 1'b0;
    pixels.red_in = '0;
    pixels.green_in = '0;
    pixels.blue_in = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_SOURCE_WIDTH;
    cfg.data = '0;
    results.ready = 1'b0;
  end

  // receiver: random stalls, plus one long hold while the sender keeps offering
  always @(posedge clk) begin
    if (long_hold) begin
      results.ready <= 1'b0;
      repeat (400) @(posedge clk);
      long_hold = 1'b0;
    end
    results.ready <= !rst && ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if ((pixels.valid && pixels.ready) || (results.valid && results.ready) ||
        (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    wait (outstanding == 0);
    repeat (12) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      pixels.valid <= 1'b0;
      @(posedge clk);
    end
    pixels.valid    <= 1'b1;
    pixels.red_in   <= r;
    pixels.green_in <= g;
    pixels.blue_in  <= b;
    do @(posedge clk); while (!pixels.ready);
    fed++;
  endtask

  function automatic logic [7:0] sample(input int style);
    case (style)
      1: return 8'hFF;
      2: return 8'h00;
      3: return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // one whole frame so the block's counters are back at zero afterwards
  task automatic send_frame(input int w, input int h, input int style);
    int n;
    write_reg(REG_SOURCE_WIDTH, w);
    write_reg(REG_SOURCE_HEIGHT, h);
    n = (w < 1 ? 1 : w) * (h < 1 ? 1 : h);
    for (int i = 0; i < n; i++)
      send_pixel(sample(style), sample(style), sample(style));
    pixels.valid <= 1'b0;
  endtask

  initial begin
    int goal;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners, odd sizes, degenerate and single-row frames
    send_frame(2, 2, 1);
    send_frame(4, 4, 3);
    send_frame(3, 3, 0);
    send_frame(6, 2, 2);
    send_frame(1, 4, 0);
    send_frame(4, 1, 0);
    send_frame(0, 3, 0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 86; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 86; end
        default: begin src_idle_pct = 32; sink_stall_pct = 32; end
      endcase
      goal = fed + 130;
      if (phase == 0) long_hold = 1'b1;
      while (fed < goal)
        send_frame($urandom_range(2, 14), $urandom_range(2, 11), $urandom_range(9) == 0 ? 3 : 0);
    end

    // tall and odd frames, run at full rate
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_frame(2, 24, 0);
    send_frame(3, 9, 0);
    send_frame(5, 7, 3);

    wait (outstanding == 0);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end
endmodule

[sim.f]
rtl/core/pld_pkg.sv
rtl/core/pld_if.sv
rtl/core/pyramid_level_decimate_blur.sv
bench/half_frame_checker.sv
bench/tb_top.sv
